/* src/wcfc_pkg.sv */
// Package for the word CRC-32 frame checker: types, constants and the CRC fold matrices.
`timescale 1ns / 1ps
`default_nettype none

package wcfc_pkg;

  // Counter width; the result fields carry the low 32 bits (zero-extended when narrower)
  localparam int unsigned CountWidth = 32;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcTop  = 32'h8000_0000;

  // Row j holds the input bits that feed output bit j
  typedef logic [31:0][31:0] crc_mat_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } in_req_t;

  typedef struct packed {
    logic        frame_ok;
    logic [31:0] computed_crc;
    logic [31:0] frames_received;
    logic [31:0] crc_error_count;
  } out_rsp_t;

  // Bit-serial fold, MSB first; only evaluated at elaboration to build the matrices
  function automatic logic [31:0] crc_fold_serial(logic [31:0] crc_in, logic [31:0] word);
    logic [31:0] crc;
    logic [31:0] mask;
    logic        top;
    crc  = crc_in;
    mask = CrcTop;
    for (int i = 0; i < 32; i++) begin
      top = |(crc & CrcTop);
      crc = {crc[30:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
      if (|(word & mask)) begin
        crc = crc ^ CrcPoly;
      end
      mask = mask >> 1;
    end
    return crc;
  endfunction

  // The fold is linear over GF(2): one matrix for the old CRC, one for the data word
  function automatic crc_mat_t build_mat(logic from_word);
    crc_mat_t    mat;
    logic [31:0] col;
    mat = '0;
    for (int i = 0; i < 32; i++) begin
      if (from_word) begin
        col = crc_fold_serial(32'h0, 32'h1 << i);
      end else begin
        col = crc_fold_serial(32'h1 << i, 32'h0);
      end
      for (int j = 0; j < 32; j++) begin
        mat[j][i] = col[j];
      end
    end
    return mat;
  endfunction

  localparam crc_mat_t CrcMatState = build_mat(1'b0);
  localparam crc_mat_t CrcMatWord  = build_mat(1'b1);

  // Combinational fold of a whole word: each output bit is an XOR tree
  function automatic logic [31:0] crc_fold_word(logic [31:0] crc, logic [31:0] word);
    logic [31:0] res;
    for (int j = 0; j < 32; j++) begin
      res[j] = ^(crc & CrcMatState[j]) ^ ^(word & CrcMatWord[j]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/word_crc32_frame_check_core.sv */
// Top level of the word CRC-32 frame checker: input register, CRC fold, result register.
`timescale 1ns / 1ps
`default_nettype none

// Word-serial CRC-32 frame checker (polynomial 0x04C11DB7, MSB first, init all ones,
// no final XOR). One 32-bit word is taken per cycle while the pipeline does not stall.
// Data words are folded into the running CRC through a combinational XOR network; a
// word flagged last_word holds the received CRC and is compared against the running
// CRC instead of being folded. Each last word yields one response with pass/fail, the
// computed CRC and saturating frame and error counts, then the CRC restarts. A last
// word passes the input register, then the result register, to give its response;
// throughput is one word per cycle while the pipeline does not stall. A data word
// produces no response. The pipeline stalls only when a response is pending and not taken.
module word_crc32_frame_check_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wcfc_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output wcfc_pkg::out_rsp_t  out_rsp_o
);

  // Input register
  logic                 in_valid_q;
  wcfc_pkg::in_req_t    in_q;
  // State
  logic [31:0]          crc_q, crc_d;
  logic [wcfc_pkg::CountWidth-1:0] frame_cnt_q, frame_cnt_d;
  logic [wcfc_pkg::CountWidth-1:0] err_cnt_q, err_cnt_d;
  // Result register
  logic                 out_valid_q;
  wcfc_pkg::out_rsp_t   rsp_q, rsp_d;

  logic                 adv;
  logic                 load_rsp;
  logic                 crc_match;

  // Stage advances unless a last word would land on an untaken response
  assign adv        = in_valid_q && (!in_q.last_word || !out_valid_q || out_ready_i);
  assign load_rsp   = adv && in_q.last_word;
  assign in_ready_o = !in_valid_q || adv;
  assign crc_match  = (crc_q == in_q.data_word);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // CRC and counter update
  always_comb begin
    crc_d       = crc_q;
    frame_cnt_d = frame_cnt_q;
    err_cnt_d   = err_cnt_q;
    if (adv) begin
      if (in_q.last_word) begin
        crc_d = wcfc_pkg::CrcInit;
        if (!(&frame_cnt_q)) begin
          frame_cnt_d = frame_cnt_q + 1'b1;
        end
        if (!crc_match && !(&err_cnt_q)) begin
          err_cnt_d = err_cnt_q + 1'b1;
        end
      end else begin
        crc_d = wcfc_pkg::crc_fold_word(crc_q, in_q.data_word);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= wcfc_pkg::CrcInit;
      frame_cnt_q <= '0;
      err_cnt_q   <= '0;
    end else begin
      crc_q       <= crc_d;
      frame_cnt_q <= frame_cnt_d;
      err_cnt_q   <= err_cnt_d;
    end
  end

  // Response build
  always_comb begin
    rsp_d.frame_ok        = crc_match;
    rsp_d.computed_crc    = crc_q;
    rsp_d.frames_received = 32'(frame_cnt_d);
    rsp_d.crc_error_count = 32'(err_cnt_d);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_rsp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Checks
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rsp |=> (crc_q == wcfc_pkg::CrcInit))
    else $error("running CRC not restarted after last word");

  a_err_le_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_cnt_q <= frame_cnt_q)
    else $error("error count exceeds frame count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_rsp && out_valid_q) |-> out_ready_i)
    else $error("pending response overwritten");

  a_rsp_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rsp |=> out_valid_o)
    else $error("last word gave no response");

endmodule

`default_nettype wire
